// ===== rtl/bqdk_pkg.sv =====
// shared types and constants for the bounded key queue with delete by key
// no dependencies; imported by every module of the block except bqdk_ram
package bqdk_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_KEY_BITS    = 16;

    // fixed field widths
    localparam int KEY_IN_W  = 16;
    localparam int CNT_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int MOVED_W   = 4;

    // capacity limit after reset, largest reportable move count
    localparam logic [CNT_W-1:0]   CAP_RESET = 5'd10;
    localparam logic [MOVED_W-1:0] MOVED_MAX = 4'd15;

    // operation carried on the input tuser
    typedef enum logic [0:0] {
        OP_ARRIVE = 1'b0,
        OP_DEPART = 1'b1
    } t_op;

    // result status carried on the output tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED  = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_ARRIVE = 2'd1,
        S_SEARCH = 2'd2,
        S_RESULT = 2'd3
    } t_state;

    // one result item
    typedef struct packed {
        t_status            status;
        logic [MOVED_W-1:0] moved_count;
        logic [CNT_W-1:0]   occupancy;
    } t_result;

endpackage

// ===== rtl/bqdk_ram.sv =====
// key storage: one write port, one read port with registered read data
// no dependencies on other modules
module bqdk_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bqdk_out_reg.sv =====
// single entry output register holding one result until the sink takes it
// depends on bqdk_pkg for the result struct
module bqdk_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bqdk_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_tvalid,
    input  logic              i_tready,
    output bqdk_pkg::t_result o_res
);
    import bqdk_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or being drained this cycle
    assign o_ready  = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_res    = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/bqdk_ctrl.sv =====
// sequencer of the key queue: circular pointers, one shared key comparator,
// rotate-and-remove search; depends on bqdk_pkg, drives bqdk_ram ports
module bqdk_ctrl #(
    parameter int QUEUE_DEPTH = bqdk_pkg::DEF_QUEUE_DEPTH,
    parameter int KEY_BITS    = bqdk_pkg::DEF_KEY_BITS,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bqdk_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bqdk_pkg::t_op              i_in_op,
    input  logic [KEY_BITS-1:0]        i_in_key,
    output logic                       o_ram_we,
    output logic [PTR_W-1:0]           o_ram_waddr,
    output logic [KEY_BITS-1:0]        o_ram_wdata,
    output logic                       o_ram_re,
    output logic [PTR_W-1:0]           o_ram_raddr,
    input  logic [KEY_BITS-1:0]        i_ram_rdata,
    output logic                       o_res_valid,
    output bqdk_pkg::t_result          o_res,
    input  logic                       i_res_ready
);
    import bqdk_pkg::*;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_state              r_state, n_state;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [CNT_W-1:0]    r_cap, n_cap;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]    r_moved, n_moved;
    t_status             r_status, n_status;

    logic w_accept;
    logic w_match;
    logic w_full;
    logic w_exhausted;

    // circular pointer step with wrap at the last slot
    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    assign w_accept    = i_in_valid && o_in_ready;
    // the shared comparator
    assign w_match     = (i_ram_rdata == r_key);
    assign w_full      = (r_count >= r_cap) || (int'(r_count) >= QUEUE_DEPTH);
    assign w_exhausted = !r_cmp_vld && (r_rd_idx == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_op == OP_DEPART) ? S_SEARCH : S_ARRIVE;
                end
            end
            S_ARRIVE: begin
                n_state = S_RESULT;
            end
            S_SEARCH: begin
                if ((r_cmp_vld && w_match) || w_exhausted) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_key       = r_key;
        n_cap       = r_cap;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_rd_ptr    = r_rd_ptr;
        n_rd_idx    = r_rd_idx;
        n_cmp_vld   = r_cmp_vld;
        n_moved     = r_moved;
        n_status    = r_status;
        o_in_ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_tail;
        o_ram_wdata = r_key;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_rd_ptr;
        o_res_valid = 1'b0;

        // capacity register write
        if (i_cfg_we) begin
            n_cap = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    n_key     = i_in_key;
                    n_rd_ptr  = r_head;
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_moved   = '0;
                end
            end
            S_ARRIVE: begin
                if (w_full) begin
                    n_status = ST_REFUSED;
                end else begin
                    o_ram_we = 1'b1;
                    n_tail   = f_inc(r_tail);
                    n_count  = r_count + 1'b1;
                    n_status = ST_APPENDED;
                end
            end
            S_SEARCH: begin
                // read issue, one entry ahead of the compare
                if (r_rd_idx < r_count) begin
                    o_ram_re  = 1'b1;
                    n_rd_ptr  = f_inc(r_rd_ptr);
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                // compare at head: remove on match, else rotate to tail
                if (r_cmp_vld) begin
                    if (w_match) begin
                        n_head   = f_inc(r_head);
                        n_count  = r_count - 1'b1;
                        n_status = ST_REMOVED;
                    end else begin
                        o_ram_we    = 1'b1;
                        o_ram_wdata = i_ram_rdata;
                        n_tail      = f_inc(r_tail);
                        n_head      = f_inc(r_head);
                        n_moved     = r_moved + 1'b1;
                    end
                end else if (w_exhausted) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            S_RESULT: begin
                o_res_valid = i_res_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // result fields; a full rotation on a miss reports no moves
    always_comb begin
        o_res.status      = r_status;
        o_res.occupancy   = r_count;
        o_res.moved_count = '0;
        if (r_status == ST_REMOVED) begin
            o_res.moved_count = (r_moved > CNT_W'(MOVED_MAX)) ? MOVED_MAX
                                                               : r_moved[MOVED_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CAP_RESET;
            r_count   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_count   <= n_count;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_rd_ptr <= n_rd_ptr;
        r_rd_idx <= n_rd_idx;
        r_moved  <= n_moved;
        r_status <= n_status;
    end

endmodule

// ===== rtl/bounded_queue_delete_by_key.sv =====
// Bounded key queue with delete by key.
// Input stream: s_axis_tuser is the operation (arrive or depart), s_axis_tdata
// the key. One result leaves on the output stream for every input transfer:
// m_axis_tuser is the status, m_axis_tdata the moved count and the occupancy.
// An arrive appends the key at the tail unless occupancy has reached the
// capacity limit (i_cfg_we / i_cfg_wdata, reset value 10) or QUEUE_DEPTH.
// A depart walks the queue from the head through the one key comparator, one
// entry per cycle, moving each miss to the tail; the first match is removed.
// A miss on every entry rotates the whole queue back to its original order.
// An arrive passes from IDLE through ARRIVE to RESULT; a depart passes from
// IDLE through SEARCH, which it leaves on a match or once every entry has
// been compared, to RESULT. One item is in work at a time; the next one can
// be taken in the cycle after its result is loaded.
// The walk rate is set by the single read port of the key memory.
// Reset (synchronous, active low) empties the queue and restores the limit;
// no clearing pass is needed. A stalled sink holds the result in the output
// register and the block waits before loading the next one.
// Depends on bqdk_pkg, bqdk_ram, bqdk_ctrl and bqdk_out_reg.
module bounded_queue_delete_by_key #(
    parameter int QUEUE_DEPTH = bqdk_pkg::DEF_QUEUE_DEPTH,
    parameter int KEY_BITS    = bqdk_pkg::DEF_KEY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bqdk_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bqdk_pkg::KEY_IN_W-1:0] s_axis_tdata,   // [15:0] key
    input  logic [0:0]                    s_axis_tuser,   // [0] operation
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [3:0] moved_count,
                                                          // [8:4] occupancy
    output logic [bqdk_pkg::STATUS_W-1:0] m_axis_tuser    // [1:0] status
);
    import bqdk_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic                w_ram_we;
    logic [PTR_W-1:0]    w_ram_waddr;
    logic [KEY_BITS-1:0] w_ram_wdata;
    logic                w_ram_re;
    logic [PTR_W-1:0]    w_ram_raddr;
    logic [KEY_BITS-1:0] w_ram_rdata;
    logic [KEY_BITS-1:0] w_key;
    logic                w_res_valid;
    logic                w_res_ready;
    t_result             w_res;
    t_result             w_out_res;

    // stored key width follows the parameter
    assign w_key = KEY_BITS'(s_axis_tdata);

    // key memory
    bqdk_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (KEY_BITS),
        .ADDR_W(PTR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_re   (w_ram_re),
        .i_raddr(w_ram_raddr),
        .o_rdata(w_ram_rdata)
    );

    // sequencer and comparator
    bqdk_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .KEY_BITS   (KEY_BITS),
        .PTR_W      (PTR_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_op    (t_op'(s_axis_tuser)),
        .i_in_key   (w_key),
        .o_ram_we   (w_ram_we),
        .o_ram_waddr(w_ram_waddr),
        .o_ram_wdata(w_ram_wdata),
        .o_ram_re   (w_ram_re),
        .o_ram_raddr(w_ram_raddr),
        .i_ram_rdata(w_ram_rdata),
        .o_res_valid(w_res_valid),
        .o_res      (w_res),
        .i_res_ready(w_res_ready)
    );

    // output register
    bqdk_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_ready (w_res_ready),
        .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready),
        .o_res   (w_out_res)
    );

    // output packing
    assign m_axis_tuser = w_out_res.status;
    assign m_axis_tdata = {7'd0, w_out_res.occupancy, w_out_res.moved_count};

`ifndef NO_ASSERTIONS
    // one item at a time: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // reported occupancy never exceeds the storage
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({2'b00, m_axis_tdata[8:4]} <= 7'(QUEUE_DEPTH)))
        else $error("occupancy beyond queue depth");

    // only a removal reports moved entries
    a_moved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_REMOVED)) |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("moved count on a result that is not a removal");
`endif

endmodule

// ===== tb/tb_bounded_queue_delete_by_key.sv =====
// self-checking testbench for bounded_queue_delete_by_key: arrive and depart transfers
// checked against an in-bench queue predictor held in a small scoreboard class
// depends on bqdk_pkg and the block's rtl only
module tb_bounded_queue_delete_by_key;
    timeunit 1ns;
    timeprecision 1ps;

    import bqdk_pkg::*;

    localparam int DEPTH         = DEF_QUEUE_DEPTH;
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 2000;
    localparam int NUM_PHASES    = 3;
    localparam int NUM_SEGMENTS  = 11;
    localparam int SEGMENT_ITEMS = 50;

    // key queue predictor plus the store of expected results
    class key_queue_scoreboard;
        logic [KEY_IN_W-1:0] held_keys[$];
        logic [CNT_W-1:0]    cap_limit;
        t_result             expected_results[$];
        int                  errors;

        function new();
            cap_limit = CAP_RESET;
            errors    = 0;
        endfunction

        function void set_limit(logic [CNT_W-1:0] value);
            cap_limit = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int occupancy();
            return held_keys.size();
        endfunction

        function logic [KEY_IN_W-1:0] pick_held_key();
            return held_keys[$urandom_range(held_keys.size() - 1)];
        endfunction

        // apply one accepted input transfer to the queue and queue its result
        function void note_transfer(t_op op, logic [KEY_IN_W-1:0] key);
            t_result res;
            int      lim;
            int      hit;
            lim             = (cap_limit > DEPTH) ? DEPTH : cap_limit;
            res.moved_count = '0;
            if (op == OP_ARRIVE) begin
                if (held_keys.size() >= lim) begin
                    res.status = ST_REFUSED;
                end else begin
                    held_keys.push_back(key);
                    res.status = ST_APPENDED;
                end
            end else begin
                hit = -1;
                foreach (held_keys[i]) begin
                    if (hit < 0 && held_keys[i] == key) hit = i;
                end
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    // entries ahead of the match go to the tail, then the match leaves
                    repeat (hit) held_keys.push_back(held_keys.pop_front());
                    void'(held_keys.pop_front());
                    res.moved_count = (hit > MOVED_MAX) ? MOVED_MAX : MOVED_W'(hit);
                    res.status      = ST_REMOVED;
                end
            end
            res.occupancy = CNT_W'(held_keys.size());
            expected_results.push_back(res);
        endfunction

        function void report(string field, int expected, int actual);
            errors++;
            if (errors <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, expected, actual);
        endfunction

        // compare one output transfer with the oldest expected result
        function void check_result(t_status status, logic [MOVED_W-1:0] moved,
                                   logic [CNT_W-1:0] occ);
            t_result exp_res;
            if (expected_results.size() == 0) begin
                report("unexpected result status", -1, status);
                return;
            end
            exp_res = expected_results.pop_front();
            if (status !== exp_res.status) report("status", exp_res.status, status);
            if (moved !== exp_res.moved_count)
                report("moved_count", exp_res.moved_count, moved);
            if (occ !== exp_res.occupancy) report("occupancy", exp_res.occupancy, occ);
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [KEY_IN_W-1:0]   s_axis_tdata  = '0;   // [15:0] key
    logic [0:0]            s_axis_tuser  = '0;   // [0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;         // [3:0] moved_count, [8:4] occupancy
    logic [STATUS_W-1:0]   m_axis_tuser;         // [1:0] status

    key_queue_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    bounded_queue_delete_by_key uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // result side: check each output transfer, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_status'(m_axis_tuser), m_axis_tdata[3:0], m_axis_tdata[8:4]);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input transfer; valid stays high when the next item follows with no gap
    task automatic send_item(t_op op, logic [KEY_IN_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= key;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_transfer(op, key);
    endtask

    // hold off the sender until every result is back and the block is idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    // random mix: departs mostly aim at held keys, arrivals often repeat a small pool
    task automatic run_segment(int items, int arrive_pct);
        logic [KEY_IN_W-1:0] pool[4];
        logic [KEY_IN_W-1:0] key;
        t_op                 op;
        pool = '{16'h0000, 16'hFFFF, KEY_IN_W'($urandom), KEY_IN_W'($urandom)};
        repeat (items) begin
            op = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_DEPART;
            if (op == OP_DEPART && sb.occupancy() > 0 && $urandom_range(99) < 75)
                key = sb.pick_held_key();
            else if ($urandom_range(1))
                key = pool[$urandom_range(3)];
            else
                key = KEY_IN_W'($urandom);
            send_item(op, key);
        end
    endtask

    initial begin
        int limit_plan[NUM_SEGMENTS] = '{31, 16, 1, 0, 4, 10, 2, 16, 8, 12, 6};
        int phase_send[NUM_PHASES]   = '{10, 64, 0};
        int phase_recv[NUM_PHASES]   = '{64, 10, 0};
        logic [KEY_IN_W-1:0] fill_keys[10] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hFFFF,
            16'hA5A5, 16'h0001, 16'h8000, 16'h1234, 16'h7FFF, 16'hFFFE};

        send_idle_pct = phase_send[0];
        recv_idle_pct = phase_recv[0];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty depart, fill to the reset limit, refusal
        send_item(OP_DEPART, 16'hFFFF);
        foreach (fill_keys[i]) send_item(OP_ARRIVE, fill_keys[i]);
        send_item(OP_ARRIVE, 16'h4321);
        // duplicate key: first one from the head goes, then a full miss, then the second copy, the head and the tail
        send_item(OP_DEPART, 16'hFFFF);
        send_item(OP_DEPART, 16'h1111);
        send_item(OP_DEPART, 16'hFFFF);
        send_item(OP_DEPART, sb.held_keys[0]);
        send_item(OP_DEPART, sb.held_keys[sb.occupancy() - 1]);
        // limit lowered under the occupancy
        write_limit(5'd3);
        send_item(OP_ARRIVE, 16'h0F0F);
        send_item(OP_DEPART, 16'h5A5A);
        // zero limit refuses every arrive
        write_limit(5'd0);
        send_item(OP_ARRIVE, 16'hF0F0);
        send_item(OP_DEPART, 16'h0000);

        // random phases over a range of limits
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct = phase_send[ph];
            recv_idle_pct = phase_recv[ph];
            for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
                write_limit((seg >= 8) ? CNT_W'($urandom_range(31))
                                       : CNT_W'(limit_plan[seg]));
                run_segment(SEGMENT_ITEMS, (seg % 2 == 0) ? 75 : 45);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
